[src/pfl_pkg.sv]
// Shared types, codes and the sequencer program of the per-CPU page free-list allocator.
package pfl_pkg;

  localparam int ADDR_W     = 56;
  localparam int BATCH_W    = 16;
  localparam int CPU_FLD_W  = 3;
  localparam int PAGE_SHIFT = 12;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 2;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH = 2'd2;

  // Register values after reset
  localparam logic [ADDR_W-1:0]  BASE_RST  = 56'd2147483648;
  localparam logic [ADDR_W-1:0]  TOP_RST   = 56'd2281701376;
  localparam logic [BATCH_W-1:0] BATCH_RST = 16'd64;
  localparam logic [ADDR_W:0]    START_RST = 57'd2147483648;

  // Program step addresses
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_DISP  = 4'd1;
  localparam logic [PC_W-1:0] S_CHK1  = 4'd2;
  localparam logic [PC_W-1:0] S_CHK2  = 4'd3;
  localparam logic [PC_W-1:0] S_PUSH  = 4'd4;
  localparam logic [PC_W-1:0] S_ALLOC = 4'd5;
  localparam logic [PC_W-1:0] S_OWN   = 4'd6;
  localparam logic [PC_W-1:0] S_TEST  = 4'd7;
  localparam logic [PC_W-1:0] S_PICK  = 4'd8;
  localparam logic [PC_W-1:0] S_MOVE  = 4'd9;
  localparam logic [PC_W-1:0] S_POP   = 4'd10;
  localparam logic [PC_W-1:0] S_POP2  = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT  = 4'd12;
  localparam logic [PC_W-1:0] S_BACK  = 4'd13;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_CHK1,
    A_CHK2,
    A_PUSH,
    A_INIT,
    A_PICK,
    A_MOVE,
    A_POP_RD,
    A_POP_WR,
    A_EMIT
  } pfl_act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_ALLOC,
    C_BAD,
    C_CPU_BAD,
    C_OWN_VALID,
    C_STEAL_DONE,
    C_SKIP,
    C_OWN_EMPTY,
    C_OUT_FREE
  } pfl_cond_t;

  typedef struct packed {
    pfl_act_t          act;
    pfl_cond_t         cond;
    logic [PC_W-1:0]   target;
  } pfl_word_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic accept;
    logic is_alloc;
    logic bad;
    logic cpu_bad;
    logic head_valid;
    logic steal_done;
    logic skip;
    logic out_free;
  } pfl_flags_t;

  // Control store: a jump is taken when the condition holds, otherwise step on
  function automatic pfl_word_t pfl_rom(input logic [PC_W-1:0] pc);
    pfl_word_t w;
    case (pc)
      S_IDLE:  w = '{A_LOAD,   C_NO_ACCEPT,  S_IDLE};
      S_DISP:  w = '{A_NONE,   C_IS_ALLOC,   S_ALLOC};
      S_CHK1:  w = '{A_CHK1,   C_NEVER,      S_IDLE};
      S_CHK2:  w = '{A_CHK2,   C_BAD,        S_EMIT};
      S_PUSH:  w = '{A_PUSH,   C_ALWAYS,     S_EMIT};
      S_ALLOC: w = '{A_INIT,   C_CPU_BAD,    S_EMIT};
      S_OWN:   w = '{A_NONE,   C_OWN_VALID,  S_POP};
      S_TEST:  w = '{A_NONE,   C_STEAL_DONE, S_POP};
      S_PICK:  w = '{A_PICK,   C_SKIP,       S_TEST};
      S_MOVE:  w = '{A_MOVE,   C_ALWAYS,     S_TEST};
      S_POP:   w = '{A_POP_RD, C_OWN_EMPTY,  S_EMIT};
      S_POP2:  w = '{A_POP_WR, C_NEVER,      S_IDLE};
      S_EMIT:  w = '{A_EMIT,   C_OUT_FREE,   S_IDLE};
      S_BACK:  w = '{A_NONE,   C_ALWAYS,     S_EMIT};
      default: w = '{A_NONE,   C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/pfl_if.sv]
// Valid/ready channel interfaces for request items and result items.
interface pfl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [pfl_pkg::CPU_FLD_W-1:0] cpu;
  logic [pfl_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output opcode, output cpu, output address, input ready);
  modport sink   (input valid, input opcode, input cpu, input address, output ready);
endinterface

interface pfl_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfl_pkg::ADDR_W-1:0] page_address;
  logic [1:0]                 status;

  modport source (output valid, output page_address, output status, input ready);
  modport sink   (input valid, input page_address, input status, output ready);
endinterface

[src/per_cpu_page_free_list_allocator.sv]
// Per-CPU LIFO page free lists with stealing: one request, one result, run by a microcoded sequencer.
//
// A free checks the address and pushes the page onto the CPU's list unless the address is rejected;
// an allocate pops the head of the CPU's own list, or answers out of memory when the CPU is unknown.
// When the own list is empty, a refill scans the CPU indexes in order, the requester's own skipped,
// and moves up to steal_batch pages from the other lists onto the own list; a refill that leaves the
// list empty answers out of memory. The sequencer runs one control step per cycle, and the single
// link memory has registered read data. A new item is taken while the previous result still waits
// in the output register. The link memory needs no clearing after reset.
module per_cpu_page_free_list_allocator #(
  parameter int CPU_COUNT  = 8,
  parameter int PAGE_COUNT = 32768
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pfl_in_if.sink                            in_ch,
  pfl_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfl_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int PIDX_W = $clog2(PAGE_COUNT);
  localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int VIC_W  = $clog2(CPU_COUNT + 1);
  localparam int AW     = pfl_pkg::ADDR_W;
  localparam int PS     = pfl_pkg::PAGE_SHIFT;

  // Configuration registers
  logic [AW-1:0]                base_r;
  logic [AW-1:0]                top_r;
  logic [pfl_pkg::BATCH_W-1:0]  batch_r;
  logic [AW:0]                  start_r;

  // Item registers
  logic                         opcode_r;
  logic [pfl_pkg::CPU_FLD_W-1:0] cpu_r;
  logic [AW-1:0]                addr_r;
  logic                         bad_r;
  logic [AW:0]                  diff_r;
  logic [PIDX_W-1:0]            page_r;
  logic [VIC_W-1:0]             victim_r;
  logic [pfl_pkg::BATCH_W-1:0]  left_r;
  logic                         own_v_r;
  logic [PIDX_W-1:0]            own_r;
  logic [1:0]                   status_r;
  logic [AW-1:0]                res_page_r;

  // List heads and link memory
  logic [PIDX_W-1:0]            head_r [CPU_COUNT];
  logic [CPU_COUNT-1:0]         hv_r;
  logic [PIDX_W:0]              link_mem [PAGE_COUNT];
  logic [PIDX_W:0]              link_rd_r;

  // Output register
  logic                         out_valid_r;
  logic [AW-1:0]                out_page_r;
  logic [1:0]                   out_status_r;

  pfl_pkg::pfl_act_t            act;
  pfl_pkg::pfl_flags_t          flags;
  logic [6:0]                   cpu_ext;
  logic [CPU_W-1:0]             cpu_idx;
  logic [CPU_W-1:0]             victim_idx;
  logic [CPU_W-1:0]             hd_idx;
  logic                         hd_ok;
  logic [PIDX_W-1:0]            hd_page;
  logic                         hd_valid;
  logic                         cpu_bad;
  logic                         bad_chk2;
  logic                         out_free;
  logic                         link_we;
  logic [PIDX_W:0]              link_wd;

  pfl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act)
  );

  // Index the head array from the CPU field or the current victim
  assign cpu_ext    = 7'(cpu_r);
  assign cpu_idx    = cpu_ext[CPU_W-1:0];
  assign victim_idx = victim_r[CPU_W-1:0];
  assign hd_idx     = (act == pfl_pkg::A_PICK) ? victim_idx : cpu_idx;
  assign hd_ok      = 7'(hd_idx) < 7'(CPU_COUNT);
  assign hd_page    = hd_ok ? head_r[hd_idx] : '0;
  assign hd_valid   = hd_ok ? hv_r[hd_idx] : 1'b0;

  assign cpu_bad  = 8'(cpu_r) >= 8'(CPU_COUNT);
  assign bad_chk2 = bad_r || (addr_r >= top_r) ||
                    (diff_r[AW:PS] >= (AW - PS + 1)'(PAGE_COUNT));
  assign out_free = !out_valid_r || out_ch.ready;

  // Gather the flags the program branches on
  always_comb begin
    flags.accept     = in_ch.valid;
    flags.is_alloc   = (opcode_r == pfl_pkg::OP_ALLOC);
    flags.bad        = bad_chk2;
    flags.cpu_bad    = cpu_bad;
    flags.head_valid = hd_valid;
    flags.steal_done = (8'(victim_r) == 8'(CPU_COUNT)) || (left_r == '0);
    flags.skip       = (8'(victim_r) == 8'(cpu_r)) || !hd_valid;
    flags.out_free   = out_free;
  end

  assign in_ch.ready = rst_n && (act == pfl_pkg::A_LOAD);

  // Configuration writes; keep the pool start rounded up to a page boundary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= pfl_pkg::BASE_RST;
      top_r   <= pfl_pkg::TOP_RST;
      batch_r <= pfl_pkg::BATCH_RST;
      start_r <= pfl_pkg::START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfl_pkg::CFG_BASE: begin
          base_r  <= cfg_data;
          start_r <= ({1'b0, cfg_data} + (AW + 1)'((1 << PS) - 1)) &
                     ~(AW + 1)'((1 << PS) - 1);
        end
        pfl_pkg::CFG_TOP:   top_r   <= cfg_data;
        pfl_pkg::CFG_BATCH: batch_r <= cfg_data[pfl_pkg::BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers driven by the current action
  always_ff @(posedge clk) begin
    case (act)
      pfl_pkg::A_LOAD: begin
        opcode_r   <= in_ch.opcode;
        cpu_r      <= in_ch.cpu;
        addr_r     <= in_ch.address;
        res_page_r <= '0;
      end
      pfl_pkg::A_CHK1: begin
        bad_r  <= cpu_bad || (addr_r[PS-1:0] != '0) || (addr_r < base_r);
        diff_r <= {1'b0, addr_r} - start_r;
      end
      pfl_pkg::A_CHK2: begin
        page_r   <= diff_r[PIDX_W+PS-1:PS];
        status_r <= bad_chk2 ? pfl_pkg::ST_BAD : pfl_pkg::ST_FREED;
      end
      pfl_pkg::A_INIT: begin
        victim_r <= '0;
        left_r   <= batch_r;
        own_v_r  <= 1'b0;
        status_r <= pfl_pkg::ST_OOM;
      end
      pfl_pkg::A_PICK: begin
        if (flags.skip) begin
          victim_r <= victim_r + 1'b1;
        end else begin
          page_r <= hd_page;
        end
      end
      pfl_pkg::A_MOVE: begin
        left_r  <= left_r - 1'b1;
        own_v_r <= 1'b1;
        own_r   <= page_r;
      end
      pfl_pkg::A_POP_RD: page_r <= hd_page;
      pfl_pkg::A_POP_WR: begin
        res_page_r <= start_r[AW-1:0] + (AW'(page_r) << PS);
        status_r   <= pfl_pkg::ST_ALLOC;
      end
      default: ;
    endcase
  end

  // Update list heads: push, move a stolen page, pop
  always_ff @(posedge clk) begin
    case (act)
      pfl_pkg::A_PUSH: head_r[cpu_idx] <= page_r;
      pfl_pkg::A_MOVE: begin
        head_r[victim_idx] <= link_rd_r[PIDX_W-1:0];
        head_r[cpu_idx]    <= page_r;
      end
      pfl_pkg::A_POP_WR: head_r[cpu_idx] <= link_rd_r[PIDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else begin
      case (act)
        pfl_pkg::A_PUSH: hv_r[cpu_idx] <= 1'b1;
        pfl_pkg::A_MOVE: begin
          hv_r[victim_idx] <= link_rd_r[PIDX_W];
          hv_r[cpu_idx]    <= 1'b1;
        end
        pfl_pkg::A_POP_WR: hv_r[cpu_idx] <= link_rd_r[PIDX_W];
        default: ;
      endcase
    end
  end

  // Link memory: a pushed page links to the old head of the list it joins
  assign link_we = (act == pfl_pkg::A_PUSH) || (act == pfl_pkg::A_MOVE);
  assign link_wd = (act == pfl_pkg::A_MOVE) ? {own_v_r, own_r} : {hd_valid, hd_page};

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[page_r] <= link_wd;
    end
    link_rd_r <= link_mem[hd_page];
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((act == pfl_pkg::A_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((act == pfl_pkg::A_EMIT) && out_free) begin
      out_page_r   <= res_page_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.page_address = out_page_r;
  assign out_ch.status       = out_status_r;

endmodule

[src/pfl_seq.sv]
// Step counter and control-store sequencer of the page allocator.
module pfl_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  pfl_pkg::pfl_flags_t flags,
  output pfl_pkg::pfl_act_t   act
);

  logic [pfl_pkg::PC_W-1:0] pc_r;
  logic [pfl_pkg::PC_W-1:0] pc_nxt;
  pfl_pkg::pfl_word_t       word;
  logic                     take;

  // Fetch the control word of the current step
  assign word = pfl_pkg::pfl_rom(pc_r);
  assign act  = word.act;

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (word.cond)
      pfl_pkg::C_NEVER:      take = 1'b0;
      pfl_pkg::C_ALWAYS:     take = 1'b1;
      pfl_pkg::C_NO_ACCEPT:  take = !flags.accept;
      pfl_pkg::C_IS_ALLOC:   take = flags.is_alloc;
      pfl_pkg::C_BAD:        take = flags.bad;
      pfl_pkg::C_CPU_BAD:    take = flags.cpu_bad;
      pfl_pkg::C_OWN_VALID:  take = flags.head_valid;
      pfl_pkg::C_STEAL_DONE: take = flags.steal_done;
      pfl_pkg::C_SKIP:       take = flags.skip;
      pfl_pkg::C_OWN_EMPTY:  take = !flags.head_valid;
      pfl_pkg::C_OUT_FREE:   take = flags.out_free;
      default:               take = 1'b1;
    endcase
    pc_nxt = take ? word.target : pc_r + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pfl_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[src/pfl_checker.sv]
// Port-level checks of the page allocator, bound to the top level.
module pfl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pfl_pkg::ADDR_W-1:0] out_page_address,
  input logic [1:0]                 out_status
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_page_address))
    else $error("result dropped or changed while stalled");

  // Only a successful allocate carries an address
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pfl_pkg::ST_ALLOC) |-> out_page_address == '0)
    else $error("non-zero address on a result that is not an allocation");

  // Allocated addresses are page aligned
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pfl_pkg::ST_ALLOC) |->
      out_page_address[pfl_pkg::PAGE_SHIFT-1:0] == '0)
    else $error("allocated address not page aligned");

  // No result appears in the cycle right after an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result offered too early after an item");

  // No result is offered straight out of reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind per_cpu_page_free_list_allocator pfl_checker u_pfl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_page_address (out_ch.page_address),
  .out_status       (out_ch.status)
);
